### design/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg: shared types and constants of the event slot allocator
// Operation codes, register indexes and reset values, table geometry, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int RV_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam int DEFAULT_EVENT_SLOTS = 256;

  // table is kept as rows of ROW_W slots
  localparam int ROW_W = 32;
  localparam int COL_W = 5;

  localparam logic [RV_W-1:0] RV_FAIL = 9'h1FF;
  localparam logic [RV_W-1:0] RV_OK   = 9'h001;
  localparam logic [RV_W-1:0] RV_ZERO = 9'h000;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_WAIT    = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_TEST    = 3'd5
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_SW_CARD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HW_CARD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IO_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_CARD = 3'd5;

  localparam logic [DATA_W-1:0] RST_SW_CARD  = 32'hF400_0002;
  localparam logic [DATA_W-1:0] RST_HW_CARD  = 32'hF000_0011;
  localparam logic [DATA_W-1:0] RST_IO_END   = 32'h0000_0004;
  localparam logic [DATA_W-1:0] RST_ERROR    = 32'h0000_8000;
  localparam logic [DATA_W-1:0] RST_TIMEOUT  = 32'h0000_0100;
  localparam logic [DATA_W-1:0] RST_NEW_CARD = 32'h0000_2000;

  typedef struct packed {
    logic [DATA_W-1:0] sw_card;
    logic [DATA_W-1:0] hw_card;
    logic [DATA_W-1:0] io_end;
    logic [DATA_W-1:0] error;
    logic [DATA_W-1:0] timeout;
    logic [DATA_W-1:0] new_card;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic needs_mem;
    logic more;
  } status_t;

endpackage

### design/event_slot_allocator.sv
// ----------------------------------------------------------------------------
// event_slot_allocator: event slot table with rotating first-free search
// Opens, closes, tests and bounds-checks event slots, one request at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time; a finished result sits in an output register,
// so the next request is accepted while it waits. Wait, enable, disable, the
// unused operation codes, opens with a zero descriptor, and closes and tests
// with out-of-range ids go from accept straight to the done state without a
// table read. Close and test read their row once and then load the result. An
// open reads one 32-slot row of the table memory per cycle starting at the hint
// row, ROWS+1 reads at most, ROWS = ceil(EVENT_SLOTS/32); a full table costs
// the most. A stalled result that is still waiting holds the next request in
// the done state until it leaves. Per-row valid flags clear the table at reset,
// so no clearing pass runs. The code registers are to be written through
// cfg_write/cfg_index/cfg_data only while idle; the block does not enforce this.
module event_slot_allocator #(
  parameter int EVENT_SLOTS = esa_pkg::DEFAULT_EVENT_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [esa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esa_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [esa_pkg::OP_W-1:0]        operation,
  input  logic [esa_pkg::DATA_W-1:0]      descriptor,
  input  logic [esa_pkg::DATA_W-1:0]      spec_code,
  input  logic [esa_pkg::DATA_W-1:0]      event_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [esa_pkg::RV_W-1:0] return_value,
  output logic                            unsupported
);
  import esa_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  esa_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  esa_datapath #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .operation    (operation),
    .descriptor   (descriptor),
    .spec_code    (spec_code),
    .event_id     (event_id),
    .cmd          (cmd),
    .status       (status),
    .return_value (return_value),
    .unsupported  (unsupported)
  );

endmodule

### design/esa_cfg_regs.sv
// ----------------------------------------------------------------------------
// esa_cfg_regs: descriptor and spec code registers
// Six write-only code registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module esa_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [esa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esa_pkg::DATA_W-1:0]      cfg_data,
  output esa_pkg::cfg_t                   cfg
);
  import esa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sw_card  <= RST_SW_CARD;
      cfg.hw_card  <= RST_HW_CARD;
      cfg.io_end   <= RST_IO_END;
      cfg.error    <= RST_ERROR;
      cfg.timeout  <= RST_TIMEOUT;
      cfg.new_card <= RST_NEW_CARD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SW_CARD:  cfg.sw_card  <= cfg_data;
        REG_HW_CARD:  cfg.hw_card  <= cfg_data;
        REG_IO_END:   cfg.io_end   <= cfg_data;
        REG_ERROR:    cfg.error    <= cfg_data;
        REG_TIMEOUT:  cfg.timeout  <= cfg_data;
        REG_NEW_CARD: cfg.new_card <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/esa_ctrl.sv
// ----------------------------------------------------------------------------
// esa_ctrl: request sequencer
// Accepts a request, steps the row search, commits, and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module esa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  esa_pkg::status_t  status,
  output esa_pkg::cmd_t     cmd
);
  import esa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.needs_mem ? S_EVAL : S_DONE;
        end
      end
      S_EVAL: begin
        if (status.more) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/esa_datapath.sv
// ----------------------------------------------------------------------------
// esa_datapath: slot table, search and result registers
// Slot table held as rows of used and status bits with per-row valid flags,
// a one-row-per-cycle free slot search from the hint, and the output register.
// ----------------------------------------------------------------------------
module esa_datapath #(
  parameter int EVENT_SLOTS = esa_pkg::DEFAULT_EVENT_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  esa_pkg::cfg_t                 cfg,
  input  logic [esa_pkg::OP_W-1:0]      operation,
  input  logic [esa_pkg::DATA_W-1:0]    descriptor,
  input  logic [esa_pkg::DATA_W-1:0]    spec_code,
  input  logic [esa_pkg::DATA_W-1:0]    event_id,
  input  esa_pkg::cmd_t                 cmd,
  output esa_pkg::status_t              status,
  output logic signed [esa_pkg::RV_W-1:0] return_value,
  output logic                          unsupported
);
  import esa_pkg::*;

  localparam int ROWS   = (EVENT_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ROW_AW + COL_W;
  localparam int VIS_W  = $clog2(ROWS + 1);
  localparam int LAST_N = EVENT_SLOTS - (ROWS - 1) * ROW_W;
  localparam logic [ROW_W-1:0] LAST_MASK =
    (LAST_N == ROW_W) ? {ROW_W{1'b1}} : ROW_W'((64'd1 << LAST_N) - 64'd1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [VIS_W-1:0]  LAST_VISIT = VIS_W'(ROWS);

  // request fields
  op_t               op_q;
  logic              stat_q;
  logic              unsup_q;
  logic [IDX_W-1:0]  ev_idx_q;

  // search and table state
  logic [ROW_AW-1:0] cur_row, cur_row_next;
  logic [VIS_W-1:0]  visit;
  logic [IDX_W-1:0]  hint;
  logic [2*ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid;
  logic [2*ROW_W-1:0] rd_raw;
  logic              rd_hit;

  // pending result and output register
  logic [RV_W-1:0]   res_rv;
  logic              res_unsup;

  // input-side decode
  op_t               op_in;
  logic              in_range;
  logic              card;
  logic              io_end_hit;
  logic              known_spec;
  logic [RV_W-1:0]   rv_load;

  // row evaluation
  logic [ROW_W-1:0]  word_used, word_stat;
  logic [ROW_W-1:0]  upper, window, exist, free;
  logic              found, last;
  logic [COL_W-1:0]  free_col, col_sel;
  logic [ROW_W-1:0]  col_oh;
  logic [IDX_W-1:0]  slot_id;
  logic [IDX_W:0]    slot_inc;
  logic [IDX_W-1:0]  hint_after;
  logic              mem_we;
  logic [2*ROW_W-1:0] wr_word;

  assign op_in      = op_t'(operation);
  assign in_range   = (event_id < DATA_W'(EVENT_SLOTS));
  assign card       = (descriptor == cfg.sw_card) || (descriptor == cfg.hw_card);
  assign io_end_hit = card && (spec_code == cfg.io_end);
  assign known_spec = card && ((spec_code == cfg.error) || (spec_code == cfg.timeout) ||
                               (spec_code == cfg.new_card));

  always_comb begin
    status.needs_mem = 1'b0;
    status.more      = (op_q == OP_OPEN) && !found && !last;
    rv_load          = RV_ZERO;
    unique case (op_in)
      OP_OPEN: begin
        status.needs_mem = (descriptor != '0);
        rv_load          = RV_FAIL;
      end
      OP_CLOSE, OP_TEST: status.needs_mem = in_range;
      OP_WAIT, OP_ENABLE, OP_DISABLE: rv_load = in_range ? RV_OK : RV_ZERO;
      default: ;
    endcase
  end

  // row read data, rows never written read as empty
  assign word_used = rd_hit ? rd_raw[ROW_W-1:0] : '0;
  assign word_stat = rd_hit ? rd_raw[2*ROW_W-1:ROW_W] : '0;

  assign upper  = {ROW_W{1'b1}} << hint[COL_W-1:0];
  assign last   = (visit == LAST_VISIT);
  assign window = (visit == '0) ? upper : (last ? ~upper : {ROW_W{1'b1}});
  assign exist  = (cur_row == LAST_ROW) ? LAST_MASK : {ROW_W{1'b1}};
  assign free   = ~word_used & exist & window;
  assign found  = |free;

  always_comb begin
    free_col = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        free_col = COL_W'(j);
      end
    end
  end

  assign slot_id    = {cur_row, free_col};
  assign slot_inc   = {1'b0, slot_id} + (IDX_W+1)'(1);
  assign hint_after = (slot_inc >= (IDX_W+1)'(EVENT_SLOTS)) ? '0 : slot_inc[IDX_W-1:0];
  assign col_sel    = (op_q == OP_OPEN) ? free_col : ev_idx_q[COL_W-1:0];
  assign col_oh     = ROW_W'(1) << col_sel;

  always_comb begin
    mem_we  = 1'b0;
    wr_word = {word_stat, word_used};
    if (cmd.commit) begin
      if (op_q == OP_OPEN) begin
        mem_we  = found;
        wr_word = {(stat_q ? (word_stat | col_oh) : (word_stat & ~col_oh)),
                   word_used | col_oh};
      end else if (op_q == OP_CLOSE) begin
        mem_we  = 1'b1;
        wr_word = {word_stat, word_used & ~col_oh};
      end
    end
  end

  always_comb begin
    if (cmd.load) begin
      cur_row_next = (op_in == OP_OPEN) ? hint[IDX_W-1:COL_W] : event_id[IDX_W-1:COL_W];
    end else if (cmd.advance) begin
      cur_row_next = (cur_row == LAST_ROW) ? '0 : cur_row + ROW_AW'(1);
    end else begin
      cur_row_next = cur_row;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_row] <= wr_word;
    end
    rd_raw <= mem[cur_row_next];
    rd_hit <= row_valid[cur_row_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      hint      <= '0;
    end else begin
      if (mem_we) begin
        row_valid[cur_row] <= 1'b1;
      end
      if (cmd.commit && (op_q == OP_OPEN) && found) begin
        hint <= hint_after;
      end else if (cmd.commit && (op_q == OP_CLOSE)) begin
        hint <= ev_idx_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row <= cur_row_next;
    if (cmd.load) begin
      op_q      <= op_in;
      stat_q    <= io_end_hit;
      unsup_q   <= !io_end_hit && !known_spec;
      ev_idx_q  <= event_id[IDX_W-1:0];
      visit     <= '0;
      res_rv    <= rv_load;
      res_unsup <= 1'b0;
    end else if (cmd.advance) begin
      visit <= visit + VIS_W'(1);
    end else if (cmd.commit) begin
      unique case (op_q)
        OP_OPEN: begin
          res_rv    <= found ? RV_W'(slot_id) : RV_FAIL;
          res_unsup <= found && unsup_q;
        end
        OP_CLOSE: res_rv <= RV_OK;
        OP_TEST:  res_rv <= {{(RV_W-1){1'b0}}, word_stat[ev_idx_q[COL_W-1:0]]};
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      return_value <= res_rv;
      unsupported  <= res_unsup;
    end
  end

endmodule

### tb/esa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esa_checker: reply predictor and scoreboard for the event slot allocator
// Tracks code register writes and accepted requests, keeps its own slot table,
// status bits and rotating hint, and compares every accepted reply in order.
// ----------------------------------------------------------------------------
module esa_checker #(
  parameter int EVENT_SLOTS = esa_pkg::DEFAULT_EVENT_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [esa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esa_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [esa_pkg::OP_W-1:0]        operation,
  input  logic [esa_pkg::DATA_W-1:0]      descriptor,
  input  logic [esa_pkg::DATA_W-1:0]      spec_code,
  input  logic [esa_pkg::DATA_W-1:0]      event_id,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [esa_pkg::RV_W-1:0] return_value,
  input  logic                            unsupported,
  output int                              fail_count,
  output int                              pending
);

  import esa_pkg::*;

  typedef struct packed {
    logic signed [RV_W-1:0] rv;
    logic                   unsup;
  } slot_reply_t;

  slot_reply_t       reply_queue [$];
  logic [DATA_W-1:0] code_reg [6];
  bit                slot_used [EVENT_SLOTS];
  bit                slot_flag [EVENT_SLOTS];
  int                hint;
  int                mismatches;

  function automatic slot_reply_t predict_slot_reply(input logic [OP_W-1:0] op,
                                                     input logic [DATA_W-1:0] desc,
                                                     input logic [DATA_W-1:0] spec,
                                                     input logic [DATA_W-1:0] id);
    slot_reply_t r;
    int slot;
    int k;
    bit card;
    bit known_spec;
    bit in_range;
    r.rv = RV_ZERO;
    r.unsup = 1'b0;
    in_range = id < EVENT_SLOTS;
    card = (desc == code_reg[REG_SW_CARD]) || (desc == code_reg[REG_HW_CARD]);
    known_spec = (spec == code_reg[REG_IO_END]) || (spec == code_reg[REG_ERROR]) ||
                 (spec == code_reg[REG_TIMEOUT]) || (spec == code_reg[REG_NEW_CARD]);
    case (op)
      OP_OPEN: begin
        slot = -1;
        if (desc != '0) begin
          for (k = 0; k < EVENT_SLOTS; k++) begin
            if (slot < 0 && !slot_used[(hint + k) % EVENT_SLOTS])
              slot = (hint + k) % EVENT_SLOTS;
          end
        end
        if (slot < 0) begin
          r.rv = RV_FAIL;
        end else begin
          slot_used[slot] = 1'b1;
          slot_flag[slot] = card && (spec == code_reg[REG_IO_END]);
          r.unsup = !(card && known_spec);
          hint = (slot + 1) % EVENT_SLOTS;
          r.rv = slot[RV_W-1:0];
        end
      end
      OP_CLOSE: begin
        if (in_range) begin
          slot_used[id] = 1'b0;
          hint = int'(id);
          r.rv = RV_OK;
        end
      end
      OP_WAIT, OP_ENABLE, OP_DISABLE: begin
        r.rv = in_range ? RV_OK : RV_ZERO;
      end
      OP_TEST: begin
        if (in_range)
          r.rv = slot_flag[id] ? RV_OK : RV_ZERO;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_reply_t want;
    int s;
    if (rst) begin
      code_reg[REG_SW_CARD]  = RST_SW_CARD;
      code_reg[REG_HW_CARD]  = RST_HW_CARD;
      code_reg[REG_IO_END]   = RST_IO_END;
      code_reg[REG_ERROR]    = RST_ERROR;
      code_reg[REG_TIMEOUT]  = RST_TIMEOUT;
      code_reg[REG_NEW_CARD] = RST_NEW_CARD;
      for (s = 0; s < EVENT_SLOTS; s++) begin
        slot_used[s] = 1'b0;
        slot_flag[s] = 1'b0;
      end
      hint = 0;
      mismatches = 0;
      reply_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          mismatches++;
          $error("unexpected reply: return_value %0d, unsupported %0b",
                 return_value, unsupported);
        end else begin
          want = reply_queue.pop_front();
          if (return_value !== want.rv) begin
            mismatches++;
            $error("return_value: expected %0d, got %0d", want.rv, return_value);
          end
          if (unsupported !== want.unsup) begin
            mismatches++;
            $error("unsupported: expected %0b, got %0b", want.unsup, unsupported);
          end
        end
      end
      if (cfg_write && cfg_index <= REG_NEW_CARD)
        code_reg[cfg_index] = cfg_data;
      if (in_valid && !in_stall)
        reply_queue.push_back(predict_slot_reply(operation, descriptor, spec_code, event_id));
    end
    pending <= reply_queue.size();
    fail_count <= mismatches;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level testbench of the event slot allocator
// Drives directed and random open, close, test and bounds-check requests
// under several code register settings, idle and output stall patterns; the checker
// predicts and compares every reply, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  import esa_pkg::*;

  localparam int               SLOTS       = DEFAULT_EVENT_SLOTS;
  localparam int               STALL_LIMIT = 5000;
  localparam logic [OP_W-1:0]  OP_SPARE_A  = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_B  = 3'd7;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [DATA_W-1:0]        cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation    = '0;
  logic [DATA_W-1:0]        descriptor   = '0;
  logic [DATA_W-1:0]        spec_code    = '0;
  logic [DATA_W-1:0]        event_id     = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [RV_W-1:0]   return_value;
  logic                     unsupported;

  int                       fail_count;
  int                       pending;
  int                       idle_pct     = 0;
  int                       stall_pct    = 0;
  int                       quiet_cycles = 0;
  logic [DATA_W-1:0]        cur_code [6];

  event_slot_allocator #(.EVENT_SLOTS(SLOTS)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .descriptor   (descriptor),
    .spec_code    (spec_code),
    .event_id     (event_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .return_value (return_value),
    .unsupported  (unsupported)
  );

  esa_checker #(.EVENT_SLOTS(SLOTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .descriptor   (descriptor),
    .spec_code    (spec_code),
    .event_id     (event_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .return_value (return_value),
    .unsupported  (unsupported),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] desc,
                              input logic [DATA_W-1:0] spec, input logic [DATA_W-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    descriptor <= desc;
    spec_code  <= spec;
    event_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_replies(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_codes();
    write_reg(REG_SW_CARD,  cur_code[REG_SW_CARD]);
    write_reg(REG_HW_CARD,  cur_code[REG_HW_CARD]);
    write_reg(REG_IO_END,   cur_code[REG_IO_END]);
    write_reg(REG_ERROR,    cur_code[REG_ERROR]);
    write_reg(REG_TIMEOUT,  cur_code[REG_TIMEOUT]);
    write_reg(REG_NEW_CARD, cur_code[REG_NEW_CARD]);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int k;
    int pick;
    int open_pct;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] desc;
    logic [DATA_W-1:0] spec;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] sw;
    logic [DATA_W-1:0] hw;

    cur_code[REG_SW_CARD]  = RST_SW_CARD;
    cur_code[REG_HW_CARD]  = RST_HW_CARD;
    cur_code[REG_IO_END]   = RST_IO_END;
    cur_code[REG_ERROR]    = RST_ERROR;
    cur_code[REG_TIMEOUT]  = RST_TIMEOUT;
    cur_code[REG_NEW_CARD] = RST_NEW_CARD;
    sw = RST_SW_CARD;
    hw = RST_HW_CARD;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero descriptor, each spec code with one of the cards, unsupported pairs
    send_request(OP_OPEN, '0, RST_IO_END, '0);
    send_request(OP_OPEN, sw, RST_IO_END, '0);
    send_request(OP_OPEN, hw, RST_ERROR, '0);
    send_request(OP_OPEN, sw, RST_TIMEOUT, '1);
    send_request(OP_OPEN, hw, RST_NEW_CARD, '0);
    send_request(OP_OPEN, '1, '1, '0);
    send_request(OP_OPEN, sw, '0, '0);
    send_request(OP_TEST, '0, '0, 32'd0);
    send_request(OP_TEST, '0, '0, 32'd1);
    send_request(OP_TEST, '1, '1, SLOTS - 1);
    send_request(OP_TEST, '0, '0, SLOTS);
    // close then reopen takes the freed slot
    send_request(OP_CLOSE, '0, '0, 32'd2);
    send_request(OP_OPEN, hw, RST_IO_END, '0);
    send_request(OP_CLOSE, '0, '0, '1);
    send_request(OP_CLOSE, '0, '0, 32'd200);
    send_request(OP_WAIT, '0, '0, 32'd0);
    send_request(OP_ENABLE, '0, '0, SLOTS - 1);
    send_request(OP_DISABLE, '0, '0, SLOTS);
    send_request(OP_WAIT, '1, '1, '1);
    send_request(OP_SPARE_A, '1, '1, 32'd0);
    send_request(OP_SPARE_B, sw, RST_IO_END, '1);
    // hint wraps past the last slot
    send_request(OP_CLOSE, '0, '0, SLOTS - 1);
    send_request(OP_OPEN, sw, RST_IO_END, '0);
    // closed slot keeps its status
    send_request(OP_CLOSE, '0, '0, 32'd0);
    send_request(OP_TEST, '0, '0, 32'd0);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1, 5: begin
          for (k = 0; k < 6; k++) cur_code[k] = $urandom;
        end
        2: begin
          for (k = 0; k < 6; k++) cur_code[k] = '0;
        end
        3: begin
          for (k = 0; k < 6; k++) cur_code[k] = '1;
        end
        4: begin
          // equal card codes, coinciding spec codes
          cur_code[REG_SW_CARD]  = $urandom;
          cur_code[REG_HW_CARD]  = cur_code[REG_SW_CARD];
          cur_code[REG_IO_END]   = $urandom;
          cur_code[REG_ERROR]    = cur_code[REG_IO_END];
          cur_code[REG_TIMEOUT]  = $urandom;
          cur_code[REG_NEW_CARD] = cur_code[REG_TIMEOUT];
        end
        6: begin
          cur_code[REG_SW_CARD]  = RST_SW_CARD;
          cur_code[REG_HW_CARD]  = RST_HW_CARD;
          cur_code[REG_IO_END]   = RST_IO_END;
          cur_code[REG_ERROR]    = RST_ERROR;
          cur_code[REG_TIMEOUT]  = RST_TIMEOUT;
          cur_code[REG_NEW_CARD] = RST_NEW_CARD;
        end
        7: begin
          for (k = 0; k < 6; k++) cur_code[k] = $urandom_range(1, 15);
        end
        default: begin
        end
      endcase
      if (phase != 0) begin
        drain_replies(6);
        write_codes();
      end

      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      open_pct = (phase == 3 || phase == 6) ? 25 : ((phase == 7) ? 50 : 65);

      for (n = 0; n < 240; n++) begin
        pick = $urandom_range(99);
        if (pick < open_pct) begin
          op = OP_OPEN;
        end else begin
          pick = $urandom_range(9);
          if (pick < 4) begin
            op = OP_CLOSE;
          end else if (pick < 7) begin
            op = OP_TEST;
          end else if (pick < 9) begin
            case ($urandom_range(2))
              0: op = OP_WAIT;
              1: op = OP_ENABLE;
              default: op = OP_DISABLE;
            endcase
          end else begin
            op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
          end
        end

        pick = $urandom_range(99);
        if (pick < 30)      desc = cur_code[REG_SW_CARD];
        else if (pick < 55) desc = cur_code[REG_HW_CARD];
        else if (pick < 65) desc = '0;
        else if (pick < 75) desc = '1;
        else                desc = $urandom;

        pick = $urandom_range(99);
        if (pick < 20)      spec = cur_code[REG_IO_END];
        else if (pick < 35) spec = cur_code[REG_ERROR];
        else if (pick < 50) spec = cur_code[REG_TIMEOUT];
        else if (pick < 65) spec = cur_code[REG_NEW_CARD];
        else if (pick < 75) spec = '0;
        else if (pick < 80) spec = '1;
        else                spec = $urandom;

        pick = $urandom_range(99);
        if (pick < 75)      id = $urandom_range(0, SLOTS - 1);
        else if (pick < 80) id = SLOTS;
        else if (pick < 85) id = '1;
        else                id = $urandom;

        send_request(op, desc, spec, id);
      end
    end

    drain_replies(20);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
